FILE: hdl/swm_pkg.sv
// Shared constants and controller/datapath interface types of the running median filter.
package swm_pkg;

  // Largest window the stores can hold.
  localparam int unsigned WindowMax   = 64;
  // Bits of one sample.
  localparam int unsigned SampleWidth = 32;
  // Bits of the window size register.
  localparam int unsigned CfgWidth    = 7;
  // Bits of a store address.
  localparam int unsigned AddrWidth   = $clog2(WindowMax);
  // Bits of a count that must also hold WindowMax itself.
  localparam int unsigned CntWidth    = $clog2(WindowMax + 1);

  // Commands from the controller to the datapath, valid for the current cycle.
  typedef struct packed {
    logic load;       // capture the accepted input sample
    logic cfg_wr;     // write the window size and flush the window
    logic old_cap;    // capture the oldest sample read from the arrival store
    logic sweep_clr;  // clear the sweep counters and flags
    logic sweep_rm;   // run the removal sweep over the sorted store
    logic sweep_ins;  // run the insertion sweep over the sorted store
    logic tail;       // final insertion write, arrival write, advance pointers
    logic med_cap;    // load the median into the output register
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;        // the window holds window_size samples
    logic sweep_done;  // all reads of the sweep issued and processed
    logic emit_next;   // this sample completes a full window
    logic out_free;    // the output register can take a new beat
  } swm_sts_t;

endpackage

FILE: hdl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/swm_ctrl.sv
// Controller state machine of the running median filter.
module swm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StOldCap = 3'd1;
  localparam logic [2:0] StRemove = 3'd2;
  localparam logic [2:0] StInsert = 3'd3;
  localparam logic [2:0] StTail   = 3'd4;
  localparam logic [2:0] StMedRd  = 3'd5;
  localparam logic [2:0] StMedCap = 3'd6;

  logic [2:0] state_q, state_d;

  // Configuration has priority over a sample in the idle state.
  assign cfg_ready_o   = (state_q == StIdle);
  assign s_axis_tready = (state_q == StIdle) && !cfg_valid_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_wr = 1'b1;
        end else if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          if (sts_i.full) begin
            state_d = StOldCap;
          end else begin
            cmd_o.sweep_clr = 1'b1;
            state_d         = StInsert;
          end
        end
      end
      StOldCap: begin
        cmd_o.old_cap   = 1'b1;
        cmd_o.sweep_clr = 1'b1;
        state_d         = StRemove;
      end
      StRemove: begin
        cmd_o.sweep_rm = 1'b1;
        if (sts_i.sweep_done) begin
          cmd_o.sweep_clr = 1'b1;
          state_d         = StInsert;
        end
      end
      StInsert: begin
        cmd_o.sweep_ins = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = StTail;
        end
      end
      StTail: begin
        cmd_o.tail = 1'b1;
        state_d    = sts_i.emit_next ? StMedRd : StIdle;
      end
      StMedRd: begin
        state_d = StMedCap;
      end
      StMedCap: begin
        if (sts_i.out_free) begin
          cmd_o.med_cap = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/swm_dpath.sv
// Datapath of the running median filter: stores, sweep logic and output register.
module swm_dpath (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  swm_pkg::swm_cmd_t                         cmd_i,
  output swm_pkg::swm_sts_t                         sts_o,
  input  logic signed [swm_pkg::SampleWidth-1:0]    sample_i,
  input  logic        [swm_pkg::CfgWidth-1:0]       window_size_i,
  input  logic                                      out_ready_i,
  output logic                                      out_valid_o,
  output logic signed [swm_pkg::SampleWidth-1:0]    median_o
);

  localparam int unsigned SW = swm_pkg::SampleWidth;
  localparam int unsigned AW = swm_pkg::AddrWidth;
  localparam int unsigned CW = swm_pkg::CntWidth;

  // Configuration and window bookkeeping.
  logic [swm_pkg::CfgWidth-1:0] window_q;
  logic [CW-1:0]                fill_q, fill_d;
  logic [CW-1:0]                slot_q, slot_d;
  logic [CW-1:0]                eff_w;
  logic [CW-1:0]                mid;
  logic [CW-1:0]                slot_inc;
  logic                         full;

  // Item payload.
  logic signed [SW-1:0] sample_q;
  logic signed [SW-1:0] old_q;

  // Sweep state.
  logic [CW-1:0]        rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]        pidx_q, pidx_d;
  logic                 pv_q, pv_d;
  logic                 found_q, found_d;
  logic                 placed_q, placed_d;
  logic signed [SW-1:0] carry_q, carry_d;
  logic [CW-1:0]        n_sel;
  logic                 sweep_en;
  logic                 issue;

  // RAM ports.
  logic          srt_we;
  logic [AW-1:0] srt_waddr;
  logic [SW-1:0] srt_wdata;
  logic [AW-1:0] srt_raddr;
  logic [SW-1:0] srt_rdata;
  logic [AW-1:0] arr_waddr;
  logic [SW-1:0] arr_rdata;
  logic signed [SW-1:0] elem;

  // Output register.
  logic                 out_valid_q;
  logic signed [SW-1:0] median_q;

  // Window size zero acts as one, sizes above the store depth saturate.
  always_comb begin
    if (window_q == '0) begin
      eff_w = CW'(1);
    end else if (CW'(window_q) > CW'(swm_pkg::WindowMax)) begin
      eff_w = CW'(swm_pkg::WindowMax);
    end else begin
      eff_w = CW'(window_q);
    end
  end

  assign full     = (fill_q == eff_w);
  assign mid      = (eff_w - CW'(1)) >> 1;
  assign slot_inc = slot_q + CW'(1);

  // Entries in the sorted store during the sweep: the full window for removal,
  // the current fill or one less than the window for insertion.
  always_comb begin
    if (cmd_i.sweep_rm) begin
      n_sel = eff_w;
    end else if (full) begin
      n_sel = eff_w - CW'(1);
    end else begin
      n_sel = fill_q;
    end
  end

  assign sweep_en = cmd_i.sweep_rm || cmd_i.sweep_ins;
  assign issue    = sweep_en && (rd_cnt_q < n_sel);
  assign elem     = $signed(srt_rdata);

  // Read address of the sorted store: sweep position, else the median rank.
  assign srt_raddr = issue ? rd_cnt_q[AW-1:0] : mid[AW-1:0];

  // Sweep processing and sorted store writes.
  always_comb begin
    rd_cnt_d  = rd_cnt_q;
    pidx_d    = pidx_q;
    pv_d      = pv_q;
    found_d   = found_q;
    placed_d  = placed_q;
    carry_d   = carry_q;
    srt_we    = 1'b0;
    srt_waddr = pidx_q[AW-1:0];
    srt_wdata = elem;
    if (cmd_i.sweep_clr) begin
      rd_cnt_d = '0;
      pv_d     = 1'b0;
      found_d  = 1'b0;
      placed_d = 1'b0;
    end else if (sweep_en) begin
      // Issue the next read while the previous element is processed.
      pv_d = issue;
      if (issue) begin
        rd_cnt_d = rd_cnt_q + CW'(1);
        pidx_d   = rd_cnt_q;
      end
      if (pv_q && cmd_i.sweep_rm) begin
        // Removal: after the matching entry, shift each element down by one.
        if (found_q) begin
          srt_we    = 1'b1;
          srt_waddr = AW'(pidx_q - CW'(1));
          srt_wdata = elem;
        end else if ((elem == old_q) || (pidx_q + CW'(1) == n_sel)) begin
          found_d = 1'b1;
        end
      end else if (pv_q) begin
        // Insertion: place the sample before the first larger element,
        // then carry each displaced element one place up.
        if (placed_q) begin
          srt_we    = 1'b1;
          srt_wdata = carry_q;
          carry_d   = elem;
        end else if (elem > sample_q) begin
          srt_we    = 1'b1;
          srt_wdata = sample_q;
          carry_d   = elem;
          placed_d  = 1'b1;
        end
      end
    end else if (cmd_i.tail) begin
      // Last entry of the insertion goes to the top of the sorted run.
      srt_we    = 1'b1;
      srt_waddr = n_sel[AW-1:0];
      srt_wdata = placed_q ? carry_q : sample_q;
    end
  end

  // The new sample takes the oldest slot once full, else the next free slot.
  assign arr_waddr = full ? slot_q[AW-1:0] : fill_q[AW-1:0];

  // Fill count and oldest slot.
  always_comb begin
    fill_d = fill_q;
    slot_d = slot_q;
    if (cmd_i.cfg_wr) begin
      fill_d = '0;
      slot_d = '0;
    end else if (cmd_i.tail) begin
      if (full) begin
        slot_d = (slot_inc >= eff_w) ? '0 : slot_inc;
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= swm_pkg::CfgWidth'(3);
      fill_q      <= '0;
      slot_q      <= '0;
      rd_cnt_q    <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      placed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) begin
        window_q <= window_size_i;
      end
      fill_q   <= fill_d;
      slot_q   <= slot_d;
      rd_cnt_q <= rd_cnt_d;
      pv_q     <= pv_d;
      found_q  <= found_d;
      placed_q <= placed_d;
      if (cmd_i.med_cap) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.old_cap) begin
      old_q <= $signed(arr_rdata);
    end
    if (cmd_i.med_cap) begin
      median_q <= elem;
    end
    pidx_q  <= pidx_d;
    carry_q <= carry_d;
  end

  // Samples in arrival order; the oldest slot is read continuously.
  swm_ram #(
    .Width(SW),
    .Depth(swm_pkg::WindowMax)
  ) u_arrival (
    .clk_i  (clk_i),
    .we_i   (cmd_i.tail),
    .waddr_i(arr_waddr),
    .wdata_i(sample_q),
    .raddr_i(slot_q[AW-1:0]),
    .rdata_o(arr_rdata)
  );

  // Samples in ascending order.
  swm_ram #(
    .Width(SW),
    .Depth(swm_pkg::WindowMax)
  ) u_sorted (
    .clk_i  (clk_i),
    .we_i   (srt_we),
    .waddr_i(srt_waddr),
    .wdata_i(srt_wdata),
    .raddr_i(srt_raddr),
    .rdata_o(srt_rdata)
  );

  // Status to the controller.
  assign sts_o.full       = full;
  assign sts_o.sweep_done = (rd_cnt_q == n_sel) && !pv_q;
  assign sts_o.emit_next  = full || (fill_q + CW'(1) == eff_w);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

FILE: hdl/sliding_window_median_unit.sv
// Top level of the running median filter over a sliding window of signed samples.
//
// Samples arrive as beats on the slave stream (s_axis_*); each beat carries one
// signed sample. Once the window holds window_size samples, every sample yields
// one beat on the master stream (m_axis_*) carrying the lower median, the
// element of rank ceil(W/2) in ascending order. While the window fills, no
// beat is produced. A write on the cfg_* channel sets window_size (zero acts
// as one, above 64 saturates to 64) and empties the window.
// One sample is processed at a time: one pass over the sorted store inserts
// it and, once the window is full, one more pass first removes the oldest
// sample; the single read port of the sorted store sets one entry per cycle.
// Reset empties the window and sets window_size to 3; the stores need no
// clearing pass. The median waits in an output register; a new sample can be
// accepted while it waits, and the block stalls only when the next median is
// ready and the receiver has not taken the previous one.
module sliding_window_median_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Slave stream. tdata: sample [31:0].
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic signed [swm_pkg::SampleWidth-1:0] s_axis_tdata,
  // Master stream. tdata: median [31:0].
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic signed [swm_pkg::SampleWidth-1:0] m_axis_tdata,
  // Window size write channel.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic        [swm_pkg::CfgWidth-1:0]    cfg_data_i
);

  swm_pkg::swm_cmd_t cmd;
  swm_pkg::swm_sts_t sts;

  // Sequencing of the removal and insertion passes.
  swm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Stores, sweep logic and output register.
  swm_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i     (s_axis_tdata),
    .window_size_i(cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .median_o     (m_axis_tdata)
  );

endmodule

FILE: verif/tb_sliding_window_median_unit.sv
// Testbench of the running median filter: random and directed streams against a predictor.
module tb_sliding_window_median_unit;

  typedef logic signed [swm_pkg::SampleWidth-1:0] sample_t;
  typedef logic [swm_pkg::CfgWidth-1:0]           cfg_t;

  // Cycles to let pass once no median is outstanding; covers one full-window sample.
  localparam int unsigned DrainCycles = 2 * swm_pkg::WindowMax + 16;
  // Number of samples in the random part.
  localparam int unsigned RandomSamples = 1200;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  // Slave stream. tdata: sample [31:0].
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  sample_t             s_axis_tdata;
  // Master stream. tdata: median [31:0].
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  sample_t             m_axis_tdata;
  // Window size write channel.
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  cfg_t                cfg_data_i;

  // Predictor state: the window in arrival order and its effective size.
  sample_t     window_q[$];
  int unsigned window_len;
  // Medians that are due but have not arrived yet, oldest first.
  sample_t     median_q[$];
  sample_t     want_median;
  int unsigned error_count    = 0;
  bit          idling_on      = 1'b1;
  int unsigned rx_hold_cycles = 0;

  sliding_window_median_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Lower median of the current window: sort a copy and take rank ceil(W/2).
  function automatic sample_t window_median();
    sample_t ordered[$];
    sample_t pick;
    int      j;
    ordered = window_q;
    for (int i = 1; i < ordered.size(); i++) begin
      pick = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > pick) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = pick;
    end
    return ordered[(ordered.size() - 1) / 2];
  endfunction

  // The oldest sample leaves a full window; a median is due once the window is full.
  function automatic void predict_sample(input sample_t s);
    if (window_q.size() >= window_len) void'(window_q.pop_front());
    window_q.push_back(s);
    if (window_q.size() == window_len) median_q.push_back(window_median());
  endfunction

  // A window size write empties the window; zero acts as one, large values saturate.
  function automatic void set_window(input cfg_t value);
    if (value == 0) begin
      window_len = 1;
    end else if (value > swm_pkg::WindowMax) begin
      window_len = swm_pkg::WindowMax;
    end else begin
      window_len = value;
    end
    window_q.delete();
  endfunction

  // Extremes, a narrow band around zero that yields many equal samples, or any value.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9)) inside
      0: return {1'b1, {(swm_pkg::SampleWidth - 1){1'b0}}};
      1: return {1'b0, {(swm_pkg::SampleWidth - 1){1'b1}}};
      [2:4]: return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one sample after a random gap and hold it until the beat is taken.
  task automatic send_sample(input sample_t s);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_sample(s);
  endtask

  // Stop offering, wait for every due median, then let a full sample time pass.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write the window size once the block is idle.
  task automatic write_window(input cfg_t value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    set_window(value);
  endtask

  // Reset window of three: extreme values, alternating bit patterns and equal samples.
  task automatic test_default_window();
    send_sample({1'b1, {(swm_pkg::SampleWidth - 1){1'b0}}});
    send_sample({1'b0, {(swm_pkg::SampleWidth - 1){1'b1}}});
    send_sample('0);
    send_sample('1);
    send_sample(sample_t'(1));
    send_sample(sample_t'(32'h5555_5555));
    send_sample(sample_t'(32'hAAAA_AAAA));
    send_sample(sample_t'(7));
    send_sample(sample_t'(7));
    send_sample(sample_t'(7));
    send_sample(sample_t'(-5));
  endtask

  // Window size zero acts as one; an even window gives the lower median.
  task automatic test_tiny_windows();
    write_window('0);
    send_sample({1'b1, {(swm_pkg::SampleWidth - 1){1'b0}}});
    send_sample({1'b0, {(swm_pkg::SampleWidth - 1){1'b1}}});
    send_sample(sample_t'(-2));
    write_window(cfg_t'(2));
    send_sample(sample_t'(10));
    send_sample(sample_t'(-10));
    send_sample(sample_t'(3));
    send_sample(sample_t'(3));
  endtask

  // A write in the middle of filling empties the window, which must fill again.
  task automatic test_flush_on_write();
    write_window(cfg_t'(5));
    send_sample(sample_t'(100));
    send_sample(sample_t'(-100));
    send_sample(sample_t'(50));
    write_window(cfg_t'(5));
    for (int i = 0; i < 6; i++) send_sample(random_sample());
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    write_window(cfg_t'(1));
    idling_on      = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_sample(random_sample());
    drain();
    idling_on = 1'b1;
  endtask

  // Random windows, largest and saturating ones included, each with a random stream.
  task automatic test_random_windows();
    int unsigned sent;
    int unsigned phase;
    int unsigned count;
    cfg_t        value;
    sent  = 0;
    phase = 0;
    while (sent < RandomSamples) begin
      case (phase)
        0: value = '1;
        1: value = cfg_t'(swm_pkg::WindowMax);
        default: begin
          case ($urandom_range(0, 9))
            0: value = '1;
            1: value = cfg_t'(swm_pkg::WindowMax + $urandom_range(0, 63));
            2: value = '0;
            3: value = cfg_t'(1);
            default: value = cfg_t'($urandom_range(2, 12));
          endcase
        end
      endcase
      write_window(value);
      idling_on = ($urandom_range(0, 3) != 0);
      count = window_len + $urandom_range(10, 60);
      for (int i = 0; i < count; i++) send_sample(random_sample());
      sent  += count;
      phase++;
    end
    idling_on = 1'b1;
  endtask

  // Receiver: a random stall before each beat, and a long hold-off on request.
  initial begin : rx_side
    int unsigned stall;
    int unsigned held;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        held           = rx_hold_cycles;
        rx_hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (held) @(posedge clk_i);
      end
      stall = idling_on ? $urandom_range(0, 8) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Compare every median beat with the oldest due median.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (median_q.size() == 0) begin
        $display("%0t: median beat %0d arrived with none due", $time, m_axis_tdata);
        error_count++;
      end else begin
        want_median = median_q.pop_front();
        if (m_axis_tdata !== want_median) begin
          $display("%0t: median expected %0d, actual %0d", $time, want_median, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    set_window(cfg_t'(3));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_tiny_windows();
    test_flush_on_write();
    test_backpressure();
    test_random_windows();
    drain();
    if (error_count == 0) begin
      $display("[sliding_window_median_unit] OK");
    end else begin
      $display("[sliding_window_median_unit] ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("[sliding_window_median_unit] ERROR");
    $finish;
  end

endmodule
